>>> hw/rtl/ihdp_pkg.sv
package ihdp_pkg;

	localparam int STATUS_W = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_UNKNOWN    = 3'd1,
		ST_BAD_MARKER = 3'd2,
		ST_BAD_PNG    = 3'd3,
		ST_TRUNC      = 3'd4,
		ST_BAD_LEN    = 3'd5
	} status_t;

	localparam logic KIND_JPEG = 1'b0;
	localparam logic KIND_PNG  = 1'b1;

	localparam logic [7:0] JPEG_SOI_0    = 8'hFF;
	localparam logic [7:0] JPEG_SOI_1    = 8'hD8;
	localparam logic [7:0] PNG_SIG_0     = 8'h89;
	localparam logic [7:0] PNG_SIG_1     = 8'h50;
	localparam logic [7:0] MARKER_PREFIX = 8'hFF;

	// SOF markers are FFC0..FFCF, less DHT (FFC4) and JPG (FFC8)
	localparam logic [11:0] SOF_BASE = 12'hFFC;
	localparam logic [3:0]  SOF_DHT  = 4'h4;
	localparam logic [3:0]  SOF_JPG  = 4'h8;

	localparam logic [7:0] CT_TRUECOLOR       = 8'd2;
	localparam logic [7:0] CT_TRUECOLOR_ALPHA = 8'd6;

	typedef logic [4:0] fidx_t;

	localparam fidx_t JM_PREFIX_CHECK = 5'd1;
	localparam fidx_t JM_LEN_LO       = 5'd3;
	localparam fidx_t SOF_PREC        = 5'd0;
	localparam fidx_t SOF_H_HI        = 5'd1;
	localparam fidx_t SOF_H_LO        = 5'd2;
	localparam fidx_t SOF_W_HI        = 5'd3;
	localparam fidx_t SOF_W_LO        = 5'd4;
	localparam fidx_t PNG_SIG_FIRST   = 5'd2;
	localparam fidx_t PNG_SIG_LAST    = 5'd7;
	localparam fidx_t PNG_W_FIRST     = 5'd16;
	localparam fidx_t PNG_W_LAST      = 5'd19;
	localparam fidx_t PNG_H_FIRST     = 5'd20;
	localparam fidx_t PNG_H_LAST      = 5'd23;
	localparam fidx_t PNG_DEPTH       = 5'd24;
	localparam fidx_t PNG_CTYPE       = 5'd25;

	function automatic logic [7:0] png_sig_tail(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h4E;
			3'd1: b = 8'h47;
			3'd2: b = 8'h0D;
			3'd3: b = 8'h0A;
			3'd4: b = 8'h1A;
			3'd5: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	typedef struct packed {
		logic       shift_en;
		logic       skip_load;
		logic       skip_dec;
		logic       cap_depth;
		logic       cap_h16;
		logic       cap_w16;
		logic       cap_h32;
		logic       cap_w32;
		logic       bpp_jpeg;
		logic       bpp_png;
		logic       prod_en;
		logic       part_en;
		logic       out_load_ok;
		logic       out_load_err;
		status_t    err_code;
		logic [2:0] sig_sel;
	} cmd_t;

	typedef struct packed {
		logic sig_jpeg;
		logic sig_png;
		logic prev_ff;
		logic is_sof;
		logic len_lt2;
		logic len_eq2;
		logic skip_one;
		logic png_sig_ok;
		logic out_free;
	} stat_t;

endpackage

>>> hw/rtl/ihdp_if.sv
interface ihdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source(output valid, output data_byte, output is_last, input ready);
	modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

interface ihdp_out_if;
	logic                          valid;
	logic                          ready;
	logic [ihdp_pkg::STATUS_W-1:0] status;
	logic                          image_kind;
	logic [31:0]                   width;
	logic [31:0]                   height;
	logic [15:0]                   bits_per_pixel;
	logic [63:0]                   byte_size;

	modport source(output valid, output status, output image_kind, output width,
		output height, output bits_per_pixel, output byte_size, input ready);
	modport sink(input valid, input status, input image_kind, input width,
		input height, input bits_per_pixel, input byte_size, output ready);
endinterface

>>> hw/rtl/ihdp_dp.sv
module ihdp_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  ihdp_pkg::cmd_t   cmd,
	output ihdp_pkg::stat_t  stat,
	ihdp_out_if.source       result
);
	import ihdp_pkg::*;

	logic [23:0] shift_q;
	logic [15:0] skip_q;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [7:0]  depth_q;
	logic [15:0] bpp_q;
	logic        kind_q;
	logic [63:0] prod_s1;
	logic [44:0] hi_s2;
	logic [44:0] lo_s2;

	logic        out_valid_q;
	status_t     status_q;
	logic        out_kind_q;
	logic [31:0] out_width_q;
	logic [31:0] out_height_q;
	logic [15:0] out_bpp_q;
	logic [63:0] out_size_q;

	logic [15:0] marker;
	logic [15:0] seg_len;
	logic [15:0] bpp_png;
	logic [12:0] bytes_pp;
	logic [64:0] size_sum;
	logic        size_sat;
	logic [63:0] size_final;

	assign marker  = shift_q[23:8];
	assign seg_len = {shift_q[7:0], data_byte};

	always_comb begin
		stat.sig_jpeg   = (shift_q[7:0] == JPEG_SOI_0) && (data_byte == JPEG_SOI_1);
		stat.sig_png    = (shift_q[7:0] == PNG_SIG_0) && (data_byte == PNG_SIG_1);
		stat.prev_ff    = (shift_q[7:0] == MARKER_PREFIX);
		stat.is_sof     = (marker[15:4] == SOF_BASE) && (marker[3:0] != SOF_DHT) &&
			(marker[3:0] != SOF_JPG);
		stat.len_lt2    = (seg_len < 16'd2);
		stat.len_eq2    = (seg_len == 16'd2);
		stat.skip_one   = (skip_q == 16'd1);
		stat.png_sig_ok = (data_byte == png_sig_tail(cmd.sig_sel));
		stat.out_free   = !out_valid_q || result.ready;
	end

	always_comb begin
		if ((data_byte == CT_TRUECOLOR) || (data_byte == CT_TRUECOLOR_ALPHA)) begin
			bpp_png = {7'd0, depth_q, 1'b0} + {8'd0, depth_q};
		end else begin
			bpp_png = {8'd0, depth_q};
		end
	end

	assign bytes_pp = bpp_q[15:3];

	// hi part lands 32 bits up; any bit beyond 64 saturates
	assign size_sum   = {1'b0, hi_s2[31:0], 32'd0} + {20'd0, lo_s2};
	assign size_sat   = (|hi_s2[44:32]) || size_sum[64];
	assign size_final = size_sat ? '1 : size_sum[63:0];

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			shift_q <= {shift_q[15:0], data_byte};
		end
		if (cmd.skip_load) begin
			skip_q <= seg_len - 16'd2;
		end else if (cmd.skip_dec) begin
			skip_q <= skip_q - 16'd1;
		end
		if (cmd.cap_depth) begin
			depth_q <= data_byte;
		end
		if (cmd.cap_h16) begin
			height_q <= {16'd0, height_q[7:0], data_byte};
		end else if (cmd.cap_h32) begin
			height_q <= {height_q[23:0], data_byte};
		end
		if (cmd.cap_w16) begin
			width_q <= {16'd0, width_q[7:0], data_byte};
		end else if (cmd.cap_w32) begin
			width_q <= {width_q[23:0], data_byte};
		end
		if (cmd.bpp_jpeg) begin
			bpp_q  <= 16'(depth_q) * 16'(data_byte);
			kind_q <= KIND_JPEG;
		end else if (cmd.bpp_png) begin
			bpp_q  <= bpp_png;
			kind_q <= KIND_PNG;
		end
		if (cmd.prod_en) begin
			prod_s1 <= 64'(width_q) * 64'(height_q);
		end
		if (cmd.part_en) begin
			hi_s2 <= 45'(prod_s1[63:32]) * 45'(bytes_pp);
			lo_s2 <= 45'(prod_s1[31:0]) * 45'(bytes_pp);
		end
		if (cmd.out_load_ok) begin
			status_q     <= ST_OK;
			out_kind_q   <= kind_q;
			out_width_q  <= width_q;
			out_height_q <= height_q;
			out_bpp_q    <= bpp_q;
			out_size_q   <= size_final;
		end else if (cmd.out_load_err) begin
			status_q     <= cmd.err_code;
			out_kind_q   <= 1'b0;
			out_width_q  <= '0;
			out_height_q <= '0;
			out_bpp_q    <= '0;
			out_size_q   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_ok || cmd.out_load_err) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = status_q;
	assign result.image_kind     = out_kind_q;
	assign result.width          = out_width_q;
	assign result.height         = out_height_q;
	assign result.bits_per_pixel = out_bpp_q;
	assign result.byte_size      = out_size_q;

endmodule

>>> hw/rtl/ihdp_ctrl.sv
module ihdp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	ihdp_in_if.sink         data,
	input  ihdp_pkg::stat_t stat,
	output ihdp_pkg::cmd_t  cmd
);
	import ihdp_pkg::*;

	typedef enum logic [9:0] {
		PH_SIG0  = 10'b00_0000_0001,
		PH_SIG1  = 10'b00_0000_0010,
		PH_JMARK = 10'b00_0000_0100,
		PH_JSKIP = 10'b00_0000_1000,
		PH_JSOF  = 10'b00_0001_0000,
		PH_PNG   = 10'b00_0010_0000,
		PH_DRAIN = 10'b00_0100_0000,
		PH_MUL1  = 10'b00_1000_0000,
		PH_MUL2  = 10'b01_0000_0000,
		PH_MUL3  = 10'b10_0000_0000
	} phase_t;

	phase_t  phase_q, phase_d;
	fidx_t   fidx_q, fidx_d;
	logic    last_q, last_d;
	logic    accept;
	logic    parsing;
	logic    got_ok;
	logic    got_err;
	status_t err_code;
	fidx_t   sig_off;

	assign data.ready = !(phase_q inside {PH_MUL1, PH_MUL2, PH_MUL3}) && stat.out_free;
	assign accept     = data.valid && data.ready;
	assign parsing    = phase_q inside {PH_SIG0, PH_SIG1, PH_JMARK, PH_JSKIP, PH_JSOF, PH_PNG};
	assign sig_off    = fidx_q - PNG_SIG_FIRST;

	always_comb begin
		cmd         = '0;
		cmd.err_code = ST_OK;
		cmd.sig_sel = sig_off[2:0];
		phase_d     = phase_q;
		fidx_d      = fidx_q;
		last_d      = last_q;
		got_ok      = 1'b0;
		got_err     = 1'b0;
		err_code    = ST_TRUNC;

		case (phase_q)
			PH_SIG0: begin
				if (accept) begin
					cmd.shift_en = 1'b1;
					phase_d      = PH_SIG1;
				end
			end
			PH_SIG1: begin
				if (accept) begin
					cmd.shift_en = 1'b1;
					if (stat.sig_jpeg) begin
						phase_d = PH_JMARK;
						fidx_d  = '0;
					end else if (stat.sig_png) begin
						phase_d = PH_PNG;
						fidx_d  = PNG_SIG_FIRST;
					end else begin
						got_err  = 1'b1;
						err_code = ST_UNKNOWN;
					end
				end
			end
			PH_JMARK: begin
				if (accept) begin
					cmd.shift_en = 1'b1;
					fidx_d       = fidx_q + 5'd1;
					if (fidx_q == JM_PREFIX_CHECK) begin
						if (!stat.prev_ff) begin
							got_err  = 1'b1;
							err_code = ST_BAD_MARKER;
						end
					end else if (fidx_q == JM_LEN_LO) begin
						fidx_d = '0;
						if (stat.is_sof) begin
							phase_d = PH_JSOF;
						end else if (stat.len_lt2) begin
							got_err  = 1'b1;
							err_code = ST_BAD_LEN;
						end else begin
							cmd.skip_load = 1'b1;
							// empty payload: next byte opens a new marker
							phase_d       = stat.len_eq2 ? PH_JMARK : PH_JSKIP;
						end
					end
				end
			end
			PH_JSKIP: begin
				if (accept) begin
					cmd.skip_dec = 1'b1;
					if (stat.skip_one) begin
						phase_d = PH_JMARK;
						fidx_d  = '0;
					end
				end
			end
			PH_JSOF: begin
				if (accept) begin
					fidx_d = fidx_q + 5'd1;
					case (fidx_q) inside
						SOF_PREC:           cmd.cap_depth = 1'b1;
						SOF_H_HI, SOF_H_LO: cmd.cap_h16   = 1'b1;
						SOF_W_HI, SOF_W_LO: cmd.cap_w16   = 1'b1;
						default: begin
							cmd.bpp_jpeg = 1'b1;
							got_ok       = 1'b1;
						end
					endcase
				end
			end
			PH_PNG: begin
				if (accept) begin
					fidx_d = fidx_q + 5'd1;
					case (fidx_q) inside
						[PNG_SIG_FIRST:PNG_SIG_LAST]: begin
							if (!stat.png_sig_ok) begin
								got_err  = 1'b1;
								err_code = ST_BAD_PNG;
							end
						end
						[PNG_W_FIRST:PNG_W_LAST]: cmd.cap_w32   = 1'b1;
						[PNG_H_FIRST:PNG_H_LAST]: cmd.cap_h32   = 1'b1;
						PNG_DEPTH:                cmd.cap_depth = 1'b1;
						PNG_CTYPE: begin
							cmd.bpp_png = 1'b1;
							got_ok      = 1'b1;
						end
						default: ;
					endcase
				end
			end
			PH_DRAIN: begin
				// drop bytes until the end of the file
				if (accept && data.is_last) begin
					phase_d = PH_SIG0;
					fidx_d  = '0;
				end
			end
			PH_MUL1: begin
				cmd.prod_en = 1'b1;
				phase_d     = PH_MUL2;
			end
			PH_MUL2: begin
				cmd.part_en = 1'b1;
				phase_d     = PH_MUL3;
			end
			PH_MUL3: begin
				cmd.out_load_ok = 1'b1;
				phase_d         = last_q ? PH_SIG0 : PH_DRAIN;
				fidx_d          = '0;
			end
			default: begin
				phase_d = PH_SIG0;
				fidx_d  = '0;
			end
		endcase

		if (accept && parsing) begin
			if (got_ok) begin
				phase_d = PH_MUL1;
				last_d  = data.is_last;
			end else if (got_err || data.is_last) begin
				cmd.out_load_err = 1'b1;
				cmd.err_code     = got_err ? err_code : ST_TRUNC;
				phase_d          = data.is_last ? PH_SIG0 : PH_DRAIN;
				fidx_d           = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG0;
			fidx_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			fidx_q  <= fidx_d;
			last_q  <= last_d;
		end
	end

endmodule

>>> hw/rtl/image_header_dimension_parser.sv
// channel | dir | beat                       | fields
// data    | in  | one byte of the image file | data_byte[7:0], is_last
// result  | out | one header summary         | status[2:0], image_kind, width[31:0],
//         |     |                            | height[31:0], bits_per_pixel[15:0],
//         |     |                            | byte_size[63:0]
//
// Header bytes and skipped JPEG segment bytes are taken one per cycle while data.ready is high.
// A good header then holds data.ready low while it forms width*height, then two 32x13
// partial products, then the saturating combine into the output register.
// Reset puts the parser at the first signature byte with no result pending.
// data.ready is low while the result register holds a beat that is not taken.
module image_header_dimension_parser (
	input logic        clk,
	input logic        arst_n,
	ihdp_in_if.sink    data,
	ihdp_out_if.source result
);
	import ihdp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ihdp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data),
		.stat   (stat),
		.cmd    (cmd)
	);

	ihdp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data.data_byte),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

>>> test/ihdp_header_checker.sv
module ihdp_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	ihdp_in_if          data,
	ihdp_out_if         result,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned results_seen,
	output int unsigned jpeg_ok,
	output int unsigned png_ok,
	output logic [5:0]  statuses_seen
);
	import ihdp_pkg::*;

	localparam logic [47:0] PNG_TAIL = 48'h4E_47_0D_0A_1A_0A;

	typedef enum logic [2:0] {
		AT_SIG0,
		AT_SIG1,
		AT_MARKER,
		AT_SKIP,
		AT_SOF,
		AT_PNG
	} parse_phase_t;

	typedef struct packed {
		status_t     status;
		logic        kind;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] bpp;
		logic [63:0] size;
	} summary_t;

	parse_phase_t phase;
	logic [4:0]   field_pos;
	logic [15:0]  skip_left;
	logic [31:0]  shift_acc;
	logic [31:0]  width_cap;
	logic [31:0]  height_cap;
	logic [7:0]   depth_cap;
	logic         holding;

	summary_t pending_summaries[$];

	task automatic restart_header();
		phase      = AT_SIG0;
		field_pos  = '0;
		skip_left  = '0;
		shift_acc  = '0;
		width_cap  = '0;
		height_cap = '0;
		depth_cap  = '0;
		holding    = 1'b0;
	endtask

	function automatic logic [63:0] sat_bytes(input logic [31:0] w, input logic [31:0] h,
		input logic [15:0] bpp);
		logic [63:0]  area;
		logic [127:0] total;
		area  = 64'(w) * 64'(h);
		total = 128'(area) * 128'(bpp[15:3]);
		return (|total[127:64]) ? '1 : total[63:0];
	endfunction

	function automatic logic is_sof(input logic [15:0] m);
		return m[15:4] == SOF_BASE && m[3:0] != SOF_DHT && m[3:0] != SOF_JPG;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic fin, output logic got,
		output summary_t s);
		logic        done;
		status_t     st;
		logic [15:0] seg_len;
		logic [15:0] bpp;
		logic [4:0]  tail_pos;
		got  = 1'b0;
		s    = '0;
		done = 1'b0;
		st   = ST_OK;
		if (holding) begin
			// swallow the rest of the file after its summary
			if (fin)
				restart_header();
		end else begin
			case (phase)
				AT_SIG0: begin
					shift_acc = {24'h0, b};
					phase     = AT_SIG1;
				end
				AT_SIG1: begin
					if (shift_acc[7:0] == JPEG_SOI_0 && b == JPEG_SOI_1) begin
						phase     = AT_MARKER;
						field_pos = '0;
					end else if (shift_acc[7:0] == PNG_SIG_0 && b == PNG_SIG_1) begin
						phase     = AT_PNG;
						field_pos = PNG_SIG_FIRST;
					end else begin
						done = 1'b1;
						st   = ST_UNKNOWN;
					end
					shift_acc = '0;
				end
				AT_MARKER: begin
					shift_acc = {shift_acc[23:0], b};
					field_pos = field_pos + 5'd1;
					if (field_pos == 5'd2) begin
						if (shift_acc[15:8] != MARKER_PREFIX) begin
							done = 1'b1;
							st   = ST_BAD_MARKER;
						end
					end else if (field_pos >= 5'd4) begin
						seg_len   = shift_acc[15:0];
						field_pos = '0;
						if (is_sof(shift_acc[31:16]))
							phase = AT_SOF;
						else if (seg_len < 16'd2) begin
							done = 1'b1;
							st   = ST_BAD_LEN;
						end else begin
							skip_left = seg_len - 16'd2;
							phase     = (skip_left == 16'd0) ? AT_MARKER : AT_SKIP;
						end
					end
				end
				AT_SKIP: begin
					skip_left = skip_left - 16'd1;
					if (skip_left == 16'd0) begin
						phase     = AT_MARKER;
						field_pos = '0;
					end
				end
				AT_SOF: begin
					if (field_pos == SOF_PREC)
						depth_cap = b;
					else if (field_pos == SOF_H_HI || field_pos == SOF_H_LO)
						height_cap = {16'h0, height_cap[7:0], b};
					else if (field_pos == SOF_W_HI || field_pos == SOF_W_LO)
						width_cap = {16'h0, width_cap[7:0], b};
					else begin
						bpp      = 16'(depth_cap) * 16'(b);
						s.status = ST_OK;
						s.kind   = KIND_JPEG;
						s.width  = width_cap;
						s.height = height_cap;
						s.bpp    = bpp;
						s.size   = sat_bytes(width_cap, height_cap, bpp);
						done     = 1'b1;
					end
					field_pos = field_pos + 5'd1;
				end
				default: begin
					if (field_pos >= PNG_SIG_FIRST && field_pos <= PNG_SIG_LAST) begin
						tail_pos = field_pos - PNG_SIG_FIRST;
						if (b != PNG_TAIL[47 - 8 * tail_pos -: 8]) begin
							done = 1'b1;
							st   = ST_BAD_PNG;
						end
					end else if (field_pos >= PNG_W_FIRST && field_pos <= PNG_W_LAST)
						width_cap = {width_cap[23:0], b};
					else if (field_pos >= PNG_H_FIRST && field_pos <= PNG_H_LAST)
						height_cap = {height_cap[23:0], b};
					else if (field_pos == PNG_DEPTH)
						depth_cap = b;
					else if (field_pos == PNG_CTYPE) begin
						bpp = {8'h00, depth_cap};
						if (b == CT_TRUECOLOR || b == CT_TRUECOLOR_ALPHA)
							bpp = bpp * 16'd3;
						s.status = ST_OK;
						s.kind   = KIND_PNG;
						s.width  = width_cap;
						s.height = height_cap;
						s.bpp    = bpp;
						s.size   = sat_bytes(width_cap, height_cap, bpp);
						done     = 1'b1;
					end
					field_pos = field_pos + 5'd1;
				end
			endcase
			if (!done && fin) begin
				done = 1'b1;
				st   = ST_TRUNC;
			end
			if (done) begin
				got = 1'b1;
				if (st != ST_OK) begin
					s        = '0;
					s.status = st;
				end
				if (fin)
					restart_header();
				else
					holding = 1'b1;
			end
		end
	endtask

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic check_result();
		summary_t seen;
		summary_t want;
		seen.status = status_t'(result.status);
		seen.kind   = result.image_kind;
		seen.width  = result.width;
		seen.height = result.height;
		seen.bpp    = result.bits_per_pixel;
		seen.size   = result.byte_size;
		results_seen++;
		if (pending_summaries.size() == 0)
			report("unrequested summary status", '0, 64'(seen.status));
		else begin
			want = pending_summaries.pop_front();
			if (seen.status !== want.status)
				report("status", 64'(want.status), 64'(seen.status));
			if (seen.kind !== want.kind)
				report("image_kind", 64'(want.kind), 64'(seen.kind));
			if (seen.width !== want.width)
				report("width", 64'(want.width), 64'(seen.width));
			if (seen.height !== want.height)
				report("height", 64'(want.height), 64'(seen.height));
			if (seen.bpp !== want.bpp)
				report("bits_per_pixel", 64'(want.bpp), 64'(seen.bpp));
			if (seen.size !== want.size)
				report("byte_size", want.size, seen.size);
			statuses_seen[want.status] = 1'b1;
			if (want.status == ST_OK) begin
				if (want.kind == KIND_PNG)
					png_ok++;
				else
					jpeg_ok++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic     got;
		summary_t s;
		if (!arst_n) begin
			restart_header();
			pending_summaries.delete();
			mismatches    = 0;
			pending       = 0;
			results_seen  = 0;
			jpeg_ok       = 0;
			png_ok        = 0;
			statuses_seen = '0;
		end else begin
			// check the outgoing beat first: a beat taken this edge cannot be its result
			if (result.valid && result.ready)
				check_result();
			if (data.valid && data.ready) begin
				parse_byte(data.data_byte, data.is_last, got, s);
				if (got)
					pending_summaries.push_back(s);
			end
			pending = pending_summaries.size();
		end
	end

endmodule

>>> test/tb.sv
module tb;
	import ihdp_pkg::*;

	localparam int ITEMS       = 600;
	localparam int MIN_FILES   = 32;
	localparam int LIMIT       = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned jpeg_ok;
	int unsigned png_ok;
	logic [5:0]  statuses_seen;

	logic        calm;
	logic        long_hold_done;
	int unsigned stall_left;
	int unsigned bytes_sent;
	int unsigned files_sent;
	int unsigned cycle_count;
	logic [7:0]  img[$];

	ihdp_in_if  data_ch();
	ihdp_out_if result_ch();

	image_header_dimension_parser i_dut (
		.clk,
		.arst_n,
		.data   (data_ch),
		.result (result_ch)
	);

	ihdp_header_checker i_checker (
		.clk,
		.arst_n,
		.data          (data_ch),
		.result        (result_ch),
		.mismatches,
		.pending,
		.results_seen,
		.jpeg_ok,
		.png_ok,
		.statuses_seen
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// zero, all ones or random, at the given width
	function automatic logic [31:0] pick_field(input int bits);
		logic [31:0] mask;
		int          r;
		mask = (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
		r    = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return mask;
		return $urandom() & mask;
	endfunction

	function automatic logic [7:0] plain_marker();
		logic [7:0] lo;
		lo = 8'($urandom_range(0, 255));
		if (lo[7:4] == SOF_BASE[3:0] && lo[3:0] != SOF_DHT && lo[3:0] != SOF_JPG)
			lo[7:4] = 4'hE;
		return lo;
	endfunction

	function automatic logic [7:0] sof_marker();
		logic [3:0] nib;
		do
			nib = 4'($urandom_range(0, 15));
		while (nib == SOF_DHT || nib == SOF_JPG);
		return {SOF_BASE[3:0], nib};
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			data_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_ch.valid     = 1'b1;
		data_ch.data_byte = b;
		data_ch.is_last   = fin;
		do
			@(posedge clk);
		while (!data_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_image();
		for (int i = 0; i < img.size(); i++)
			put_byte(img[i], i == img.size() - 1);
		img.delete();
		files_sent++;
	endtask

	task automatic push16(input logic [15:0] v);
		img.push_back(v[15:8]);
		img.push_back(v[7:0]);
	endtask

	task automatic push32(input logic [31:0] v);
		push16(v[31:16]);
		push16(v[15:0]);
	endtask

	task automatic add_random(input int n);
		repeat (n) img.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_segment(input logic [7:0] lo, input int n);
		img.push_back(MARKER_PREFIX);
		img.push_back(lo);
		push16(16'(n + 2));
		add_random(n);
	endtask

	task automatic add_sof(input logic [7:0] lo, input logic [15:0] len, input logic [7:0] prec,
		input logic [15:0] h, input logic [15:0] w, input logic [7:0] comps);
		img.push_back(MARKER_PREFIX);
		img.push_back(lo);
		push16(len);
		img.push_back(prec);
		push16(h);
		push16(w);
		img.push_back(comps);
	endtask

	task automatic add_png(input logic [31:0] w, input logic [31:0] h, input logic [7:0] depth,
		input logic [7:0] ctype);
		img.push_back(PNG_SIG_0);
		img.push_back(PNG_SIG_1);
		push32(32'h4E47_0D0A);
		push16(16'h1A0A);
		// IHDR chunk length and tag
		push32(32'd13);
		push32(32'h4948_4452);
		push32(w);
		push32(h);
		img.push_back(depth);
		img.push_back(ctype);
	endtask

	task automatic directed_images();
		calm = 1'b1;
		img = '{8'hFF};
		send_image();
		img = '{8'h12, 8'h34, 8'h56, 8'h78};
		send_image();
		img = '{8'h89, 8'h51};
		send_image();
		img = '{8'hFF, 8'hD8};
		send_image();
		img = '{8'hFF, 8'hD8, 8'h7F, 8'hE0, 8'h00, 8'h10};
		send_image();
		img = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h01, 8'hAA};
		send_image();
		img = '{8'hFF, 8'hD8, 8'hFF, 8'hFE, 8'h00, 8'h00};
		send_image();
		// skip DHT, JPG, an empty segment and an FF00 segment, then the widest SOF
		img = '{8'hFF, 8'hD8};
		add_segment({SOF_BASE[3:0], SOF_DHT}, 3);
		add_segment({SOF_BASE[3:0], SOF_JPG}, 1);
		add_segment(8'hE0, 0);
		add_segment(8'h00, 2);
		add_sof(8'hC0, 16'h0011, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		add_random(2);
		send_image();
		// SOF length left unchecked, all fields zero, summary on the last byte
		img = '{8'hFF, 8'hD8};
		add_sof(8'hCF, 16'h0000, 8'h00, 16'h0000, 16'h0000, 8'h00);
		send_image();
		calm = 1'b0;
		img = '{8'hFF, 8'hD8};
		add_segment(8'hDB, 5);
		add_sof(8'hC2, 16'h0011, 8'd8, 16'h01E0, 16'h0280, 8'd3);
		add_random(4);
		send_image();
		// end inside a skipped segment, then inside the SOF fields
		img = '{8'hFF, 8'hD8};
		add_segment(8'hE0, 16);
		repeat (13) void'(img.pop_back());
		send_image();
		img = '{8'hFF, 8'hD8};
		add_sof(8'hC1, 16'h0011, 8'd12, 16'h1234, 16'h5678, 8'd1);
		repeat (2) void'(img.pop_back());
		send_image();
		add_png('1, '1, 8'hFF, CT_TRUECOLOR_ALPHA);
		add_random(3);
		send_image();
		add_png(32'h8000_0000, 32'd1, 8'd16, CT_TRUECOLOR);
		send_image();
		add_png(32'd0, 32'd5, 8'd8, 8'd3);
		add_random(1);
		send_image();
		add_png(32'd7, 32'd9, 8'd1, 8'd0);
		send_image();
		add_png(32'd640, 32'd480, 8'd16, 8'd4);
		send_image();
		// signature broken on the first and on the last checked byte
		add_png(32'd1, 32'd1, 8'd8, 8'd0);
		img[2] = 8'h4F;
		send_image();
		add_png(32'd1, 32'd1, 8'd8, 8'd0);
		img[7] = 8'h0B;
		send_image();
		add_png(32'd100, 32'd100, 8'd8, CT_TRUECOLOR);
		while (img.size() > 21)
			void'(img.pop_back());
		send_image();
	endtask

	task automatic random_jpeg();
		img = '{JPEG_SOI_0, JPEG_SOI_1};
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 99) < 5)
				add_segment(plain_marker(), $urandom_range(7, 200));
			else
				add_segment(plain_marker(), $urandom_range(0, 6));
		end
		add_sof(sof_marker(), 16'($urandom_range(0, 65535)), 8'(pick_field(8)),
			16'(pick_field(16)), 16'(pick_field(16)), 8'(pick_field(8)));
	endtask

	task automatic random_png();
		logic [31:0] w;
		logic [31:0] h;
		logic [7:0]  depth;
		logic [7:0]  ctype;
		w = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4096) : pick_field(32);
		h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4096) : pick_field(32);
		case ($urandom_range(0, 5))
			0: depth = 8'd1;
			1: depth = 8'd2;
			2: depth = 8'd4;
			3: depth = 8'd8;
			4: depth = 8'd16;
			default: depth = 8'(pick_field(8));
		endcase
		case ($urandom_range(0, 5))
			0: ctype = 8'd0;
			1: ctype = CT_TRUECOLOR;
			2: ctype = 8'd3;
			3: ctype = 8'd4;
			4: ctype = CT_TRUECOLOR_ALPHA;
			default: ctype = 8'($urandom_range(0, 255));
		endcase
		add_png(w, h, depth, ctype);
	endtask

	task automatic random_image();
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (r < 45)
			random_jpeg();
		else if (r < 80)
			random_png();
		else begin
			case ($urandom_range(0, 2))
				1: img = '{JPEG_SOI_0, JPEG_SOI_1};
				2: img = '{PNG_SIG_0, PNG_SIG_1};
				default: img.delete();
			endcase
			add_random($urandom_range(1, 10));
		end
		if (r < 80) begin
			add_random($urandom_range(0, 3));
			r = $urandom_range(0, 99);
			// corrupt one bit, or cut the file short
			if (r < 12) begin
				idx      = $urandom_range(0, img.size() - 1);
				img[idx] = img[idx] ^ (8'd1 << $urandom_range(0, 7));
			end else if (r < 22) begin
				idx = $urandom_range(1, img.size() - 1);
				while (img.size() > idx)
					void'(img.pop_back());
			end
		end
		send_image();
	endtask

	initial begin
		data_ch.valid     = 1'b0;
		data_ch.data_byte = '0;
		data_ch.is_last   = 1'b0;
		arst_n            = 1'b0;
		calm              = 1'b1;
		bytes_sent        = 0;
		files_sent        = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_images();
		while (bytes_sent < ITEMS || files_sent < MIN_FILES) begin
			calm = ($urandom_range(0, 3) == 0);
			random_image();
		end
		data_ch.valid = 1'b0;
		calm          = 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in %0d image files; %0d summaries checked",
			bytes_sent, files_sent, results_seen);
		$display("Decoded %0d JPEG and %0d PNG headers; status codes seen (bit per code): %b",
			jpeg_ok, png_ok, statuses_seen);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		stall_left      = 0;
		long_hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && results_seen >= 6) begin
				// hold off while the sender keeps offering bytes, so the block backs up
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = 1'b1;
				stall_left      = gap_len();
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ihdp_pkg.sv
hw/rtl/ihdp_if.sv
hw/rtl/ihdp_dp.sv
hw/rtl/ihdp_ctrl.sv
hw/rtl/image_header_dimension_parser.sv
test/ihdp_header_checker.sv
test/tb.sv
